// ===== rtl/core/bbd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bilinear Bayer demosaic.
package bbd_pkg;

	localparam int FW_BITS = 13;
	localparam int FH_BITS = 16;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [FW_BITS-1:0] FW_RESET = 13'd640;
	localparam logic [FH_BITS-1:0] FH_RESET = 16'd480;

	// Register index, taken from paddr[2]
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Site kind: {row is odd, column is odd}
	localparam logic [1:0] SITE_G_ON_GB = 2'b00;
	localparam logic [1:0] SITE_BLUE    = 2'b01;
	localparam logic [1:0] SITE_RED     = 2'b10;
	localparam logic [1:0] SITE_G_ON_RG = 2'b11;

	// floor(x/3) == (x*683) >> 11 for every x up to 1020
	localparam logic [10:0] RECIP3       = 11'd683;
	localparam int          RECIP3_SHIFT = 11;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PW + 1;

	// 3x3 window, element [row*3 + col], row 0 on top, col 0 oldest
	typedef logic [8:0][7:0] bbd_win_t;

	typedef struct packed {
		logic hl;
		logic hr;
		logic vu;
		logic vd;
		logic row_odd;
		logic col_odd;
	} bbd_site_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} bbd_pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       end_of_row;
		logic       end_of_frame;
		logic       last_of_run;
	} bbd_result_t;

	// Per-request control carried down the pipe
	typedef struct packed {
		logic emit_a;
		logic emit_b;
		logic a_hl;
		logic b_hl;
		logic vu;
		logic vd;
		logic row_odd;
		logic a_col_odd;
		logic eof;
		logic bank_sel;
	} bbd_ctrl_t;

	// Truncated mean of up to four 8-bit values
	function automatic logic [7:0] bbd_mean(input logic [9:0] s, input logic [2:0] n);
		logic [20:0] prod;
		logic [7:0]  m;
		prod = 21'(s) * 21'(RECIP3);
		case (n)
			3'd1:    m = s[7:0];
			3'd2:    m = s[8:1];
			3'd3:    m = prod[RECIP3_SHIFT+7:RECIP3_SHIFT];
			3'd4:    m = s[9:2];
			default: m = 8'd0;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/core/bbd_in_if.sv =====
`timescale 1ns / 1ps
// Bayer sample channel: valid/ready with request type and raw sample.
interface bbd_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] raw_sample;

	modport source(output valid, req_type, raw_sample, input ready);
	modport sink(input valid, req_type, raw_sample, output ready);
endinterface

// ===== rtl/core/bbd_out_if.sv =====
`timescale 1ns / 1ps
// RGB pixel channel: valid/ready with colour and framing flags.
interface bbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       end_of_row;
	logic       end_of_frame;
	logic       last_of_run;

	modport source(output valid, red, green, blue, end_of_row, end_of_frame, last_of_run,
		input ready);
	modport sink(input valid, red, green, blue, end_of_row, end_of_frame, last_of_run,
		output ready);
endinterface

// ===== rtl/core/bbd_pixel_calc.sv =====
`timescale 1ns / 1ps
// Bilinear interpolation of one pixel from its 3x3 neighbourhood.
module bbd_pixel_calc import bbd_pkg::*; (
	input  bbd_win_t   win,
	input  bbd_site_t  site,
	output bbd_pixel_t pix
);

	logic [9:0] hs, vs, ds, hvs;
	logic [2:0] hc, vc, dc, hvc;
	logic [7:0] m_h, m_v, m_d, m_hv;
	logic [7:0] own;

	always_comb begin
		hs = '0; hc = '0;
		vs = '0; vc = '0;
		ds = '0; dc = '0;
		if (site.hl) begin hs = hs + 10'(win[3]); hc = hc + 3'd1; end
		if (site.hr) begin hs = hs + 10'(win[5]); hc = hc + 3'd1; end
		if (site.vu) begin vs = vs + 10'(win[1]); vc = vc + 3'd1; end
		if (site.vd) begin vs = vs + 10'(win[7]); vc = vc + 3'd1; end
		if (site.hl && site.vu) begin ds = ds + 10'(win[0]); dc = dc + 3'd1; end
		if (site.hr && site.vu) begin ds = ds + 10'(win[2]); dc = dc + 3'd1; end
		if (site.hl && site.vd) begin ds = ds + 10'(win[6]); dc = dc + 3'd1; end
		if (site.hr && site.vd) begin ds = ds + 10'(win[8]); dc = dc + 3'd1; end
		hvs = hs + vs;
		hvc = hc + vc;
	end

	assign own  = win[4];
	assign m_h  = bbd_mean(hs, hc);
	assign m_v  = bbd_mean(vs, vc);
	assign m_d  = bbd_mean(ds, dc);
	assign m_hv = bbd_mean(hvs, hvc);

	always_comb begin
		unique case ({site.row_odd, site.col_odd})
			SITE_G_ON_GB: begin
				pix.red = m_v; pix.green = own; pix.blue = m_h;
			end
			SITE_BLUE: begin
				pix.red = m_d; pix.green = m_hv; pix.blue = own;
			end
			SITE_RED: begin
				pix.red = own; pix.green = m_hv; pix.blue = m_d;
			end
			SITE_G_ON_RG: begin
				pix.red = m_h; pix.green = own; pix.blue = m_v;
			end
			default: begin
				pix.red = '0; pix.green = '0; pix.blue = '0;
			end
		endcase
	end

endmodule

// ===== rtl/core/bbd_out_fifo.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two results a cycle, hands out one.
module bbd_out_fifo import bbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_a,
	input  logic        push_b,
	input  bbd_result_t data_a,
	input  bbd_result_t data_b,
	output logic        room,
	bbd_out_if.source   rgb
);

	bbd_result_t             entries_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   count_q;
	logic                    pop;
	bbd_result_t             head;

	assign head         = entries_q[rd_ptr_q];
	assign rgb.valid    = (count_q != '0);
	assign rgb.red      = head.red;
	assign rgb.green    = head.green;
	assign rgb.blue     = head.blue;
	assign rgb.end_of_row   = head.end_of_row;
	assign rgb.end_of_frame = head.end_of_frame;
	assign rgb.last_of_run  = head.last_of_run;
	assign pop          = rgb.valid & rgb.ready;

	// Room for a full pair from the last pipe stage
	assign room = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_a) entries_q[wr_ptr_q] <= data_a;
		if (push_b) entries_q[wr_ptr_q + FIFO_PW'(push_a)] <= data_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PW'(push_a) + FIFO_PW'(push_b);
			rd_ptr_q <= rd_ptr_q + FIFO_PW'(pop);
			count_q  <= count_q + FIFO_CNT_W'(push_a) + FIFO_CNT_W'(push_b)
				- FIFO_CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/core/bayer_bilinear_demosaic_unit.sv =====
`timescale 1ns / 1ps
// Streaming GBRG Bayer to RGB demosaic, bilinear, one row of delay.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------
//  bayer   | in  | valid/ready         | req_type, raw_sample
//  rgb     | out | valid/ready         | red, green, blue, end_of_row,
//          |     |                     | end_of_frame, last_of_run
//  apb     | in  | psel/penable/pready | paddr, pwdata, prdata (frame size)
//
// One request per clock while bayer.ready is high. Requests pass the read and
// window stages into the 4-entry result queue; one ending a row after the first
// gives two results. bayer.ready drops only while that queue holds three or more
// results. Line stores: two MAX_WIDTH x 8 RAMs by row parity, read per request,
// written per sample, same column; reset clears counters, window, queue.
module bayer_bilinear_demosaic_unit import bbd_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	bbd_in_if.sink             bayer,
	bbd_out_if.source          rgb,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (CW > FW_BITS) ? CW : FW_BITS;

	logic [FW_BITS-1:0] frame_width_q;
	logic [FH_BITS-1:0] frame_height_q;
	logic [AW-1:0]      col_q;
	logic [FH_BITS-1:0] row_q;

	logic [EW-1:0]      fw_ext;
	logic [CW-1:0]      w_eff;
	logic [FH_BITS-1:0] h_eff;
	logic               cfg_wr;
	logic               adv;
	logic               fifo_room;
	logic               row_at_end, drop, restart, take, last_col, wr_bank;
	logic [AW-1:0]      c_cur;
	logic [FH_BITS-1:0] r_cur;
	bbd_ctrl_t          ctrl_d;

	logic               valid_s1;
	bbd_ctrl_t          ctrl_s1;
	logic [7:0]         bot_s1, bank0_rd_s1, bank1_rd_s1;
	logic [7:0]         top_s1, mid_s1;

	logic               valid_s2;
	bbd_ctrl_t          ctrl_s2;
	bbd_win_t           window_q;

	logic [7:0]         bank0_q [MAX_WIDTH];
	logic [7:0]         bank1_q [MAX_WIDTH];

	bbd_win_t           win_b;
	bbd_site_t          site_a, site_b;
	bbd_pixel_t         pix_a, pix_b;
	bbd_result_t        res_a, res_b;
	logic               push_a, push_b;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign fw_ext = EW'(frame_width_q);
	assign w_eff  = (frame_width_q == '0) ? CW'(1) :
		(fw_ext > EW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(fw_ext);
	assign h_eff  = (frame_height_q == '0) ? FH_BITS'(1) : frame_height_q;

	// Request decode against the raster counters
	assign row_at_end = (row_q == h_eff);
	assign drop       = bayer.req_type & ~row_at_end;   // flush outside a drain
	assign restart    = ~bayer.req_type & row_at_end;   // sample abandons a drain
	assign c_cur      = restart ? '0 : col_q;
	assign r_cur      = restart ? '0 : row_q;
	assign adv        = fifo_room;
	assign bayer.ready = adv;
	assign take       = bayer.valid & adv & ~drop;
	assign last_col   = ((CW'(c_cur) + CW'(1)) == w_eff);
	assign wr_bank    = r_cur[0];

	always_comb begin
		ctrl_d.emit_a    = (r_cur != '0) && (c_cur != '0);
		ctrl_d.emit_b    = (r_cur != '0) && last_col;
		ctrl_d.a_hl      = (c_cur > AW'(1));
		ctrl_d.b_hl      = (c_cur != '0);
		ctrl_d.vu        = (r_cur > FH_BITS'(1));
		ctrl_d.vd        = (r_cur != h_eff);
		ctrl_d.row_odd   = ~r_cur[0];
		ctrl_d.a_col_odd = ~c_cur[0];
		ctrl_d.eof       = (r_cur == h_eff);
		ctrl_d.bank_sel  = r_cur[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= bayer.req_type ? '0 : r_cur + FH_BITS'(1);
			end else begin
				col_q <= c_cur + AW'(1);
				row_q <= r_cur;
			end
		end
	end

	// Line stores: the bank of this row's parity holds row r-2 and takes row r
	always_ff @(posedge clk) begin
		if (take) begin
			bank0_rd_s1 <= bank0_q[c_cur];
			if (!bayer.req_type && !wr_bank) bank0_q[c_cur] <= bayer.raw_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bank1_rd_s1 <= bank1_q[c_cur];
			if (!bayer.req_type && wr_bank) bank1_q[c_cur] <= bayer.raw_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctrl_s1 <= ctrl_d;
			bot_s1  <= bayer.req_type ? 8'd0 : bayer.raw_sample;
		end
	end

	assign top_s1 = ctrl_s1.bank_sel ? bank1_rd_s1 : bank0_rd_s1;
	assign mid_s1 = ctrl_s1.bank_sel ? bank0_rd_s1 : bank1_rd_s1;

	// Pipe control and window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			window_q <= '0;
			ctrl_s2  <= '0;
		end else if (adv) begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				ctrl_s2     <= ctrl_s1;
				window_q[0] <= window_q[1];
				window_q[1] <= window_q[2];
				window_q[2] <= top_s1;
				window_q[3] <= window_q[4];
				window_q[4] <= window_q[5];
				window_q[5] <= mid_s1;
				window_q[6] <= window_q[7];
				window_q[7] <= window_q[8];
				window_q[8] <= bot_s1;
			end
		end
	end

	// Second pixel is centred on the newest column; its right side is never used
	always_comb begin
		win_b    = '0;
		win_b[0] = window_q[1];
		win_b[1] = window_q[2];
		win_b[3] = window_q[4];
		win_b[4] = window_q[5];
		win_b[6] = window_q[7];
		win_b[7] = window_q[8];
	end

	always_comb begin
		site_a.hl      = ctrl_s2.a_hl;
		site_a.hr      = 1'b1;
		site_a.vu      = ctrl_s2.vu;
		site_a.vd      = ctrl_s2.vd;
		site_a.row_odd = ctrl_s2.row_odd;
		site_a.col_odd = ctrl_s2.a_col_odd;
		site_b.hl      = ctrl_s2.b_hl;
		site_b.hr      = 1'b0;
		site_b.vu      = ctrl_s2.vu;
		site_b.vd      = ctrl_s2.vd;
		site_b.row_odd = ctrl_s2.row_odd;
		site_b.col_odd = ~ctrl_s2.a_col_odd;
	end

	bbd_pixel_calc u_calc_a (
		.win  (window_q),
		.site (site_a),
		.pix  (pix_a)
	);

	bbd_pixel_calc u_calc_b (
		.win  (win_b),
		.site (site_b),
		.pix  (pix_b)
	);

	always_comb begin
		res_a.red          = pix_a.red;
		res_a.green        = pix_a.green;
		res_a.blue         = pix_a.blue;
		res_a.end_of_row   = 1'b0;
		res_a.end_of_frame = 1'b0;
		res_a.last_of_run  = ~ctrl_s2.emit_b;
		res_b.red          = pix_b.red;
		res_b.green        = pix_b.green;
		res_b.blue         = pix_b.blue;
		res_b.end_of_row   = 1'b1;
		res_b.end_of_frame = ctrl_s2.eof;
		res_b.last_of_run  = 1'b1;
	end

	assign push_a = adv & valid_s2 & ctrl_s2.emit_a;
	assign push_b = adv & valid_s2 & ctrl_s2.emit_b;

	bbd_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_a (push_a),
		.push_b (push_b),
		.data_a (res_a),
		.data_b (res_b),
		.room   (fifo_room),
		.rgb    (rgb)
	);

endmodule

// ===== rtl/core/bbd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the demosaic unit, bound to the top level.
module bbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       end_of_row,
	input logic       end_of_frame,
	input logic       last_of_run
);

	// An empty output side never holds back requests
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no result pending");

	// First result after an idle output must follow an accepted request
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 3))
		else $error("result without a matching request");

	// Frame end is always a row end and closes its run
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> end_of_row && last_of_run)
		else $error("end of frame without end of row");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({red, green, blue, end_of_row, end_of_frame, last_of_run}))
		else $error("stalled result changed");

endmodule

bind bayer_bilinear_demosaic_unit bbd_checker u_bbd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (bayer.valid),
	.in_ready     (bayer.ready),
	.out_valid    (rgb.valid),
	.out_ready    (rgb.ready),
	.red          (rgb.red),
	.green        (rgb.green),
	.blue         (rgb.blue),
	.end_of_row   (rgb.end_of_row),
	.end_of_frame (rgb.end_of_frame),
	.last_of_run  (rgb.last_of_run)
);
